@@ src/rslf_pkg.sv @@
`timescale 1ns / 1ps

package rslf_pkg;

  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned PHASE_W   = 16;
  localparam int unsigned CHANNELS  = 4;
  localparam int unsigned IN_DATA_W = 96;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_W     = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam int unsigned MAX_PIXELS_DEF = 64;

  localparam logic [TIME_W-1:0]  HOLD_RST   = 32'd1000;
  localparam logic [LEVEL_W-1:0] STEP_RST   = 8'd32;
  localparam logic [PIXEL_W-1:0] PIXELS_RST = 16'd1;

  // register indexes of the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD   = 2'd0,
    CFG_STEP   = 2'd1,
    CFG_PIXELS = 2'd2
  } rslf_cfg_idx_t;

  // per-tick control shared by all channel slew units
  typedef struct packed {
    logic               snap;
    logic [LEVEL_W-1:0] step;
  } rslf_ctl_t;

endpackage

@@ src/rslf_slew.sv @@
`timescale 1ns / 1ps

module rslf_slew (
  input  logic [rslf_pkg::LEVEL_W-1:0] level,
  input  logic [rslf_pkg::LEVEL_W-1:0] target,
  input  rslf_pkg::rslf_ctl_t          ctl,
  output logic [rslf_pkg::LEVEL_W-1:0] level_nxt
);

  logic [rslf_pkg::LEVEL_W-1:0] base;
  logic [rslf_pkg::LEVEL_W-1:0] gap_up;
  logic [rslf_pkg::LEVEL_W-1:0] gap_dn;

  // hard cut snaps to the target before the slew step
  assign base   = ctl.snap ? target : level;
  assign gap_up = target - base;
  assign gap_dn = base - target;

  always_comb begin
    if (target > base) begin
      level_nxt = base + ((gap_up > ctl.step) ? ctl.step : gap_up);
    end else if (target < base) begin
      level_nxt = base - ((gap_dn > ctl.step) ? ctl.step : gap_dn);
    end else begin
      level_nxt = base;
    end
  end

endmodule

@@ src/rgbw_slew_limited_follower_top.sv @@
`timescale 1ns / 1ps
// input register, one pass of clamp-and-add logic, output register driving out_tdata
// throughput: one word per cycle unless out_tready stalls the output register
// in_tready only drops when both the input register and the output register are held by a stall
// reset (rst_n low, synchronous): pipeline emptied, channel levels and last receive time cleared,
// config registers back to hold 1000 ms, step 32, pixel count 1

module rgbw_slew_limited_follower_top #(
  parameter int unsigned MAX_PIXELS = rslf_pkg::MAX_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // now_ms[31:0], rx_ms[63:32], red_in[71:64], green_in[79:72], blue_in[87:80],
  // white_in[95:88]
  input  logic [rslf_pkg::IN_DATA_W-1:0]  in_tdata,
  // frame_present[0], hard_cut[1]
  input  logic [rslf_pkg::IN_USER_W-1:0]  in_tuser,
  // result words
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], white_out[31:24],
  // peak_level[39:32], pixels_driven[47:40], phase_ms[63:48]
  output logic [rslf_pkg::OUT_W-1:0]      out_tdata,
  // config writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rslf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rslf_pkg::CFG_W-1:0]      cfg_data
);

  localparam int unsigned LW = rslf_pkg::LEVEL_W;
  localparam int unsigned TW = rslf_pkg::TIME_W;
  localparam int unsigned NC = rslf_pkg::CHANNELS;
  localparam logic [rslf_pkg::PIXEL_W-1:0] MaxPx = rslf_pkg::PIXEL_W'(MAX_PIXELS);

  // config registers
  logic [TW-1:0]                  hold_r;
  logic [LW-1:0]                  step_r;
  logic [rslf_pkg::PIXEL_W-1:0]   pixels_r;

  // input stage
  logic                           s1_vld_r;
  logic [TW-1:0]                  s1_now_r;
  logic [TW-1:0]                  s1_rx_r;
  logic [LW-1:0]                  s1_lvl_in_r [NC];
  logic                           s1_present_r;
  logic                           s1_cut_r;

  // kept state
  logic [LW-1:0]                  lvl_r [NC];
  logic [TW-1:0]                  last_rx_r;

  // output stage
  logic                           out_vld_r;
  logic [rslf_pkg::OUT_W-1:0]     out_data_r;

  logic                           in_fire;
  logic                           s1_fire;
  logic                           out_free;
  logic                           frame_ok;
  logic [TW-1:0]                  age;
  logic                           hold_on;
  logic [LW-1:0]                  target [NC];
  logic [LW-1:0]                  lvl_nxt [NC];
  logic [LW-1:0]                  peak_lo;
  logic [LW-1:0]                  peak_hi;
  logic [LW-1:0]                  peak;
  logic [LW-1:0]                  px;
  rslf_pkg::rslf_ctl_t            ctl;

  // handshakes: output register frees when empty or taken this cycle
  assign out_free  = !out_vld_r || out_tready;
  assign s1_fire   = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // config writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= rslf_pkg::HOLD_RST;
      step_r   <= rslf_pkg::STEP_RST;
      pixels_r <= rslf_pkg::PIXELS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rslf_pkg::rslf_cfg_idx_t'(cfg_index))
        rslf_pkg::CFG_HOLD:   hold_r   <= cfg_data;
        rslf_pkg::CFG_STEP:   step_r   <= cfg_data[LW-1:0];
        rslf_pkg::CFG_PIXELS: pixels_r <= cfg_data[rslf_pkg::PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_r       <= in_tdata[31:0];
      s1_rx_r        <= in_tdata[63:32];
      s1_lvl_in_r[0] <= in_tdata[71:64];
      s1_lvl_in_r[1] <= in_tdata[79:72];
      s1_lvl_in_r[2] <= in_tdata[87:80];
      s1_lvl_in_r[3] <= in_tdata[95:88];
      s1_present_r   <= in_tuser[0];
      s1_cut_r       <= in_tuser[1];
    end
  end

  // a frame with a zero receive time counts as no frame
  assign frame_ok = s1_present_r && (s1_rx_r != '0);
  // frame age with 32-bit wrap; stale frames run at half level
  assign age      = s1_now_r - s1_rx_r;
  assign hold_on  = age > hold_r;

  assign ctl.snap = frame_ok && s1_cut_r && (s1_rx_r != last_rx_r);
  assign ctl.step = step_r;

  for (genvar c = 0; c < NC; c++) begin : g_ch
    assign target[c] = !frame_ok ? '0 :
                       hold_on   ? (s1_lvl_in_r[c] >> 1) : s1_lvl_in_r[c];

    rslf_slew u_slew (
      .level     (lvl_r[c]),
      .target    (target[c]),
      .ctl       (ctl),
      .level_nxt (lvl_nxt[c])
    );
  end

  // peak of the four slewed levels
  assign peak_lo = (lvl_nxt[1] > lvl_nxt[0]) ? lvl_nxt[1] : lvl_nxt[0];
  assign peak_hi = (lvl_nxt[3] > lvl_nxt[2]) ? lvl_nxt[3] : lvl_nxt[2];
  assign peak    = (peak_hi > peak_lo) ? peak_hi : peak_lo;

  // pixel count clamped to the fixture maximum
  assign px = (pixels_r > MaxPx) ? MaxPx[LW-1:0] : pixels_r[LW-1:0];

  // kept state moves once per tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        lvl_r[i] <= '0;
      end
      last_rx_r <= '0;
    end else if (s1_fire) begin
      for (int i = 0; i < NC; i++) begin
        lvl_r[i] <= lvl_nxt[i];
      end
      if (frame_ok) begin
        last_rx_r <= s1_rx_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {s1_now_r[rslf_pkg::PHASE_W-1:0], px, peak,
                     lvl_nxt[3], lvl_nxt[2], lvl_nxt[1], lvl_nxt[0]};
    end
  end

  // peak never below any channel of the same word
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r[39:32] >= out_data_r[7:0]) &&
                  (out_data_r[39:32] >= out_data_r[15:8]) &&
                  (out_data_r[39:32] >= out_data_r[23:16]) &&
                  (out_data_r[39:32] >= out_data_r[31:24]))
    else $error("peak below a channel");

  // reported pixel count stays within the fixture maximum
  a_px: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ({8'd0, out_data_r[47:40]} <= MaxPx))
    else $error("pixel count above maximum");

  // a counted frame is remembered for edge detection
  a_edge: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && frame_ok |=> last_rx_r == $past(s1_rx_r))
    else $error("receive time not tracked");

  // an empty input stage never blocks the input
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("input blocked while input stage empty");

  // a tick without a frame never raises channel 0
  a_fade: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !frame_ok |=> lvl_r[0] <= $past(lvl_r[0]))
    else $error("channel rose without a frame");

endmodule

@@ dv/rgbw_slew_limited_follower_top_test.sv @@
`timescale 1ns / 1ps

module rgbw_slew_limited_follower_top_test;

  localparam int unsigned LEVEL_W   = rslf_pkg::LEVEL_W;
  localparam int unsigned TIME_W    = rslf_pkg::TIME_W;
  localparam int unsigned PIXEL_W   = rslf_pkg::PIXEL_W;
  localparam int unsigned PHASE_W   = rslf_pkg::PHASE_W;
  localparam int unsigned CHANNELS  = rslf_pkg::CHANNELS;
  localparam int unsigned IN_DATA_W = rslf_pkg::IN_DATA_W;
  localparam int unsigned IN_USER_W = rslf_pkg::IN_USER_W;
  localparam int unsigned OUT_W     = rslf_pkg::OUT_W;
  localparam int unsigned CFG_IDX_W = rslf_pkg::CFG_IDX_W;
  localparam int unsigned CFG_W     = rslf_pkg::CFG_W;

  localparam int unsigned MAX_PX = rslf_pkg::MAX_PIXELS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES = 10;
  localparam int unsigned TICKS_PER_PHASE = 110;
  // no register sits behind this index, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // input word, lowest field last
  typedef struct packed {
    logic [LEVEL_W-1:0] white;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
    logic [TIME_W-1:0]  rx;
    logic [TIME_W-1:0]  now;
  } tick_t;

  typedef struct packed {
    logic hard_cut;
    logic frame_present;
  } tick_flags_t;

  // result word, lowest field last
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] pixels;
    logic [LEVEL_W-1:0] peak;
    logic [LEVEL_W-1:0] white;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
  } levels_t;

  // predicts the slew-limited levels and checks them against the block
  class level_scoreboard;
    logic [TIME_W-1:0]  hold_ms;
    logic [LEVEL_W-1:0] step;
    logic [PIXEL_W-1:0] pixels;
    logic [LEVEL_W-1:0] level[CHANNELS];
    logic [TIME_W-1:0]  seen_rx;
    levels_t            expected_levels_q[$];
    int                 errors;
    int                 checked;

    function new();
      hold_ms = rslf_pkg::HOLD_RST;
      step    = rslf_pkg::STEP_RST;
      pixels  = rslf_pkg::PIXELS_RST;
      seen_rx = '0;
      foreach (level[c]) level[c] = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        rslf_pkg::CFG_HOLD:   hold_ms = val;
        rslf_pkg::CFG_STEP:   step    = val[LEVEL_W-1:0];
        rslf_pkg::CFG_PIXELS: pixels  = val[PIXEL_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] step_toward(logic [LEVEL_W-1:0] lvl,
                                             logic [LEVEL_W-1:0] tgt);
      logic [LEVEL_W-1:0] gap;
      if (tgt > lvl) begin
        gap = tgt - lvl;
        return lvl + ((gap > step) ? step : gap);
      end
      if (tgt < lvl) begin
        gap = lvl - tgt;
        return lvl - ((gap > step) ? step : gap);
      end
      return lvl;
    endfunction

    function void note_input(tick_t t, tick_flags_t f);
      logic [LEVEL_W-1:0] target[CHANNELS];
      logic [TIME_W-1:0]  age;
      logic               stale;
      levels_t            r;
      foreach (target[c]) target[c] = '0;
      if (f.frame_present && t.rx != '0) begin
        age   = t.now - t.rx;
        stale = age > hold_ms;
        target[0] = t.red >> stale;
        target[1] = t.green >> stale;
        target[2] = t.blue >> stale;
        target[3] = t.white >> stale;
        // snap only on a new receive time
        if (f.hard_cut && t.rx != seen_rx)
          foreach (level[c]) level[c] = target[c];
        seen_rx = t.rx;
      end
      foreach (level[c]) level[c] = step_toward(level[c], target[c]);
      r.red    = level[0];
      r.green  = level[1];
      r.blue   = level[2];
      r.white  = level[3];
      r.peak   = level[0];
      foreach (level[c]) if (level[c] > r.peak) r.peak = level[c];
      r.pixels = (pixels > MAX_PX) ? LEVEL_W'(MAX_PX) : pixels[LEVEL_W-1:0];
      r.phase  = t.now[PHASE_W-1:0];
      expected_levels_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task compare_field(string name, logic [PHASE_W-1:0] got, logic [PHASE_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(logic [OUT_W-1:0] word);
      levels_t got;
      levels_t want;
      got = levels_t'(word);
      if (expected_levels_q.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing expected", word));
        return;
      end
      want = expected_levels_q.pop_front();
      compare_field("red_out", PHASE_W'(got.red), PHASE_W'(want.red));
      compare_field("green_out", PHASE_W'(got.green), PHASE_W'(want.green));
      compare_field("blue_out", PHASE_W'(got.blue), PHASE_W'(want.blue));
      compare_field("white_out", PHASE_W'(got.white), PHASE_W'(want.white));
      compare_field("peak_level", PHASE_W'(got.peak), PHASE_W'(want.peak));
      compare_field("pixels_driven", PHASE_W'(got.pixels), PHASE_W'(want.pixels));
      compare_field("phase_ms", got.phase, want.phase);
      checked++;
    endtask

    function int pending();
      return expected_levels_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  level_scoreboard sb = new();

  // phases with no idling at all on either side
  bit calm;
  int unsigned cycle_cnt;

  // the frame that the random stream is currently following
  logic [TIME_W-1:0]  frame_rx;
  logic [LEVEL_W-1:0] frame_lv[CHANNELS];
  int                 frame_left;

  rgbw_slew_limited_follower_top #(
    .MAX_PIXELS(MAX_PX)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 16) return $urandom_range(1, 3);
    if (roll < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // full-scale and dark levels show up often
  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // result side: stall runs and ready runs, changes at the falling edge
  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready = 1'b1;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  // every accepted result word goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // called at a falling edge, returns at a falling edge with in_tvalid still high
  task automatic send_tick(tick_t t, tick_flags_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = t;
    in_tuser  = f;
    do @(posedge clk); while (!in_tready);
    sb.note_input(t, f);
    @(negedge clk);
  endtask

  task automatic send_directed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] rx,
                               logic [4*LEVEL_W-1:0] wbgr, logic present, logic cut);
    tick_t       t;
    tick_flags_t f;
    t.now = now;
    t.rx  = rx;
    {t.white, t.blue, t.green, t.red} = wbgr;
    f.frame_present = present;
    f.hard_cut      = cut;
    send_tick(t, f);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    repeat (pick_gap() % 4) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop sending and let the pipeline drain before touching registers
  task automatic settle();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // first phases hit the extremes, later ones pick settings at random;
  // upper bits beyond each register width carry junk that must be dropped
  task automatic configure(int ph);
    case (ph)
      0: begin
        cfg_write(rslf_pkg::CFG_HOLD, 32'h0000_0000);
        cfg_write(rslf_pkg::CFG_STEP, 32'h5A5A_A500);
        cfg_write(rslf_pkg::CFG_PIXELS, 32'h1234_FFFF);
      end
      1: begin
        cfg_write(rslf_pkg::CFG_HOLD, 32'hFFFF_FFFF);
        cfg_write(rslf_pkg::CFG_STEP, 32'hA5A5_5AFF);
        cfg_write(rslf_pkg::CFG_PIXELS, 32'hEDCB_0000);
      end
      2: begin
        cfg_write(rslf_pkg::CFG_PIXELS, 32'h0000_0040);
        cfg_write(rslf_pkg::CFG_STEP, 32'h0000_0001);
        cfg_write(rslf_pkg::CFG_HOLD, 32'h0000_0001);
      end
      3: begin
        cfg_write(rslf_pkg::CFG_PIXELS, 32'hFFFF_0041);
        cfg_write(CFG_IDX_SPARE, $urandom());
        cfg_write(rslf_pkg::CFG_STEP, 32'h0000_0080);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: cfg_write(rslf_pkg::CFG_HOLD, 32'h0);
          1: cfg_write(rslf_pkg::CFG_HOLD, 32'hFFFF_FFFF);
          2: cfg_write(rslf_pkg::CFG_HOLD, $urandom_range(0, 3000));
          default: cfg_write(rslf_pkg::CFG_HOLD, $urandom());
        endcase
        case ($urandom_range(0, 4))
          0: cfg_write(rslf_pkg::CFG_STEP, 32'h0);
          1: cfg_write(rslf_pkg::CFG_STEP, 32'hFF);
          2: cfg_write(rslf_pkg::CFG_STEP, $urandom_range(1, 8));
          3: ;
          default: cfg_write(rslf_pkg::CFG_STEP, $urandom());
        endcase
        if ($urandom_range(0, 1) == 0)
          cfg_write(rslf_pkg::CFG_PIXELS, {16'($urandom_range(0, 16'hFFFF)),
                                           16'(MAX_PX - 4 + $urandom_range(0, 8))});
        else
          cfg_write(rslf_pkg::CFG_PIXELS, $urandom());
        if ($urandom_range(0, 2) == 0) cfg_write(CFG_IDX_SPARE, $urandom());
      end
    endcase
  endtask

  // mostly a frame held over several ticks with ages around the hold
  // threshold; the rest is raw noise
  task automatic make_tick(output tick_t t, output tick_flags_t f);
    logic [TIME_W-1:0] age;
    if ($urandom_range(0, 9) == 0) begin
      t = tick_t'({$urandom(), $urandom(), $urandom()});
      f = tick_flags_t'(2'($urandom_range(0, 3)));
      return;
    end
    if (frame_left == 0) begin
      frame_left = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0: frame_rx = '0;
        1: ;  // same receive time, new colors: no edge
        default: frame_rx = $urandom();
      endcase
      foreach (frame_lv[c]) frame_lv[c] = pick_level();
    end
    frame_left--;
    // live color change without a new receive time
    if ($urandom_range(0, 4) == 0) frame_lv[2'($urandom_range(0, CHANNELS - 1))] = pick_level();
    case ($urandom_range(0, 6))
      0: age = $urandom_range(0, 64);
      1: age = sb.hold_ms;
      2: age = sb.hold_ms + 1;
      3: age = sb.hold_ms - 1;
      4: age = $urandom();
      5: age = sb.hold_ms + $urandom_range(0, 200) - 100;
      default: age = $urandom_range(0, 4000);
    endcase
    t.rx    = frame_rx;
    t.now   = frame_rx + age;
    t.red   = frame_lv[0];
    t.green = frame_lv[1];
    t.blue  = frame_lv[2];
    t.white = frame_lv[3];
    f.frame_present = ($urandom_range(0, 9) != 0);
    f.hard_cut      = ($urandom_range(0, 2) == 0);
  endtask

  initial begin
    tick_t       t;
    tick_flags_t f;
    // every input known from time zero
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cycle_cnt  = 0;
    calm       = 1'b0;
    frame_rx   = 32'h1;
    frame_left = 0;
    foreach (frame_lv[c]) frame_lv[c] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words at the reset settings: hold 1000 ms, step 32
    // no frame at all, time zero
    send_directed(32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
    // frame flagged present but with a zero timestamp counts as absent
    send_directed(32'h10, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // hard cut on a new frame snaps everything to full scale
    send_directed(32'd100, 32'd100, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // same receive time with hard cut set: no snap, slew down by a step
    send_directed(32'd150, 32'd100, 32'h0, 1'b1, 1'b1);
    // age exactly at the hold threshold keeps full targets
    send_directed(32'd1100, 32'd100, 32'h00_32_64_C8, 1'b1, 1'b0);
    // one past the threshold halves the targets
    send_directed(32'd1101, 32'd100, 32'h00_32_64_C8, 1'b1, 1'b0);
    // age wraps across zero: receive time above current time
    send_directed(32'd5, 32'hFFFF_FFFF, 32'h04_03_02_01, 1'b1, 1'b1);
    // largest possible age, snap to halved full scale
    send_directed(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // not present while the timestamp is nonzero: targets go to zero
    send_directed(32'hFFFF_FFFF, 32'h1357_9BDF, 32'hA5_5A_C3_3C, 1'b0, 1'b1);
    // last receive time unchanged by the absent frame: no edge here
    send_directed(32'h8000_0010, 32'h8000_0000, 32'hF0_0F_AA_55, 1'b1, 1'b1);
    // live frame without cut, levels slew toward the targets by up to a step each tick
    send_directed(32'h1234_5678, 32'h1234_5600, 32'hF0_0F_AA_55, 1'b1, 1'b0);
    send_directed(32'h1234_5679, 32'h1234_5600, 32'hF0_0F_AA_55, 1'b1, 1'b0);
    send_directed(32'h1234_567A, 32'h1234_5600, 32'hF0_0F_AA_55, 1'b1, 1'b0);
    // fresh frame with cut from a mid level, then slew back to dark
    send_directed(32'h0000_FFFF, 32'h0000_FF00, 32'h80_01_FE_7F, 1'b1, 1'b1);
    send_directed(32'hFFFF_0000, 32'h0000_FF00, 32'h00_00_00_00, 1'b0, 1'b0);
    send_directed(32'hEDCB_A987, 32'h0000_0000, 32'h00_00_00_00, 1'b1, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      configure(ph);
      calm = (ph % 4 == 3);
      repeat (TICKS_PER_PHASE) begin
        make_tick(t, f);
        send_tick(t, f);
      end
    end
    calm = 1'b0;
    in_tvalid = 1'b0;

    // drain, then keep watching for any stray word
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
